// File: sv/disk_guid_hash_macros.svh
// disk_guid_hash_macros.svh: assertion macros shared by the disk guid hash rtl
// expects clk and arst_n to be visible where a macro is used
`ifndef DISK_GUID_HASH_MACROS_SVH
`define DISK_GUID_HASH_MACROS_SVH

// same-cycle implication, checks off while in reset
`define DGH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checks off while in reset
`define DGH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/dgh_pkg.sv
// dgh_pkg: payload types, register indexes and hash constants for disk_guid_hash
// no dependencies
package dgh_pkg;

	localparam int unsigned CfgDataW = 64;
	localparam int unsigned SectorW  = 17;

	// register indexes of the configuration port
	typedef enum logic [0:0] {
		CFG_CAPACITY = 1'b0,
		CFG_SECTOR   = 1'b1
	} dgh_cfg_idx_t;

	localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

	localparam logic [SectorW-1:0] SECTOR_RESET = 17'd512;

	localparam logic [3:0] GUID_VERSION = 4'h5;
	localparam logic [1:0] GUID_VARIANT = 2'b10;

	typedef struct packed {
		logic [7:0] id_byte;
		logic       no_byte;
		logic       last;
	} dgh_in_t;

	typedef struct packed {
		logic [63:0] guid_low;
		logic [63:0] guid_high;
	} dgh_out_t;

endpackage

// File: sv/disk_guid_hash.sv
// disk_guid_hash: top level, folds identifier bytes into a 128-bit disk guid
// depends on dgh_pkg and disk_guid_hash_macros.svh
//
// For each identifier byte, a first step registers the partial products of the
// two 64-bit constant multiplies (FNV-1a lane and add lane), a second sums them
// back into the lane registers; byte_stall is high while a byte waits in the
// multiply stage, and a new byte is taken only once that byte has left the
// stage. The item marked last also finalises (capacity and sector size folded
// in, version 5 and variant bits forced) into a result register that the
// guid side drains independently; the input side keeps taking bytes while a
// guid waits, and only a second last item stalls until the first guid is taken.
// An empty identifier is one item with no_byte and last both set.
module disk_guid_hash
	import dgh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  dgh_cfg_idx_t        cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  dgh_in_t             byte_item,
	output logic                guid_valid,
	input  logic                guid_stall,
	output dgh_out_t            guid
);

	`include "disk_guid_hash_macros.svh"

	localparam logic [31:0] PrimeLo = FNV_PRIME[31:0];
	localparam logic [31:0] PrimeHi = FNV_PRIME[63:32];
	localparam logic [31:0] BasisLo = FNV_BASIS[31:0];
	localparam logic [31:0] BasisHi = FNV_BASIS[63:32];

	// partial products of one 64-bit multiply, modulo 2^64
	typedef struct packed {
		logic [63:0] ll;
		logic [31:0] lh;
		logic [31:0] hl;
	} dgh_pp_t;

	typedef struct packed {
		dgh_pp_t xr;
		dgh_pp_t ad;
		logic    no_byte;
		logic    last;
	} dgh_stage_t;

	logic [63:0]        capacity_q;
	logic [SectorW-1:0] sector_q;
	logic [63:0]        xor_lane_q;
	logic [63:0]        add_lane_q;
	logic               s1_valid;
	dgh_stage_t         s1_q;
	dgh_stage_t         s0_d;
	logic               accept;
	logic               s1_adv;
	logic [63:0]        xa;
	logic [63:0]        aa;
	logic [63:0]        xor_next;
	logic [63:0]        add_next;
	logic [63:0]        xor_fin;
	logic [63:0]        add_fin;
	dgh_out_t           guid_d;
	logic               guid_valid_q;
	dgh_out_t           guid_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
			sector_q   <= SECTOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAPACITY: capacity_q <= cfg_wdata;
				CFG_SECTOR:   sector_q   <= cfg_wdata[SectorW-1:0];
				default:      ;
			endcase
		end
	end

	assign byte_stall = s1_valid;
	assign accept     = byte_valid && !byte_stall;
	// a finishing last item needs the result register free
	assign s1_adv     = s1_valid && !(s1_q.last && guid_valid_q && guid_stall);

	// first step: fold the byte in and form partial products
	always_comb begin
		xa = xor_lane_q ^ {56'd0, byte_item.id_byte};
		aa = add_lane_q + {56'd0, byte_item.id_byte};
		s0_d.xr.ll   = 64'(xa[31:0]) * 64'(PrimeLo);
		s0_d.xr.lh   = xa[31:0] * PrimeHi;
		s0_d.xr.hl   = xa[63:32] * PrimeLo;
		s0_d.ad.ll   = 64'(aa[31:0]) * 64'(BasisLo);
		s0_d.ad.lh   = aa[31:0] * BasisHi;
		s0_d.ad.hl   = aa[63:32] * BasisLo;
		s0_d.no_byte = byte_item.no_byte;
		s0_d.last    = byte_item.last;
	end

	// second step: sum partial products, finalise on the last item
	always_comb begin
		xor_next = s1_q.xr.ll + {s1_q.xr.lh + s1_q.xr.hl, 32'd0};
		add_next = s1_q.ad.ll + {s1_q.ad.lh + s1_q.ad.hl, 32'd0};
		xor_fin  = s1_q.no_byte ? xor_lane_q : xor_next;
		add_fin  = s1_q.no_byte ? add_lane_q : add_next;
		guid_d.guid_low  = xor_fin ^ capacity_q;
		guid_d.guid_high = add_fin ^ {{(64-SectorW){1'b0}}, sector_q};
		guid_d.guid_low[55:52] = GUID_VERSION;
		guid_d.guid_high[7:6]  = GUID_VARIANT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid     <= 1'b0;
			xor_lane_q   <= FNV_BASIS;
			add_lane_q   <= FNV_PRIME;
			guid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
			if (s1_adv && s1_q.last) begin
				xor_lane_q <= FNV_BASIS;
				add_lane_q <= FNV_PRIME;
			end else if (s1_adv && !s1_q.no_byte) begin
				xor_lane_q <= xor_next;
				add_lane_q <= add_next;
			end
			if (s1_adv && s1_q.last) begin
				guid_valid_q <= 1'b1;
			end else if (!guid_stall) begin
				guid_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= s0_d;
		end
		if (s1_adv && s1_q.last) begin
			guid_q <= guid_d;
		end
	end

	assign guid_valid = guid_valid_q;
	assign guid       = guid_q;

	`DGH_ASSERT_NEXT(a_transfer_fills_stage, accept, s1_valid && byte_stall,
		"accepted byte did not reach the multiply stage")
	`DGH_ASSERT_NEXT(a_last_gives_guid, s1_adv && s1_q.last,
		guid_valid && xor_lane_q == FNV_BASIS && add_lane_q == FNV_PRIME,
		"last item did not give a guid and reseed the lanes")
	`DGH_ASSERT_NEXT(a_no_byte_keeps_lanes, s1_valid && s1_q.no_byte && !s1_q.last,
		$stable(xor_lane_q) && $stable(add_lane_q),
		"item without a byte changed a lane")
	`DGH_ASSERT_NOW(a_guid_fixed_bits, guid_valid,
		guid.guid_low[55:52] == GUID_VERSION && guid.guid_high[7:6] == GUID_VARIANT,
		"guid version or variant bits wrong")

endmodule

// File: test/tb.sv
// tb: self-checking bench for disk_guid_hash, predicts each guid from the byte transfers
// depends on dgh_pkg and the disk_guid_hash rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dgh_pkg::*;

	localparam int unsigned CycleLimit  = 600000;
	localparam int unsigned DrainCycles = 16;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	dgh_cfg_idx_t        cfg_index = CFG_CAPACITY;
	logic [CfgDataW-1:0] cfg_wdata = '0;
	logic                byte_valid = 1'b0;
	logic                byte_stall;
	dgh_in_t             byte_item = '0;
	logic                guid_valid;
	logic                guid_stall = 1'b0;
	dgh_out_t            guid;

	// predicted hash state and register copies
	logic [63:0]         fnv_acc;
	logic [63:0]         sum_acc;
	logic [63:0]         capacity_m;
	logic [SectorW-1:0]  sector_m;
	dgh_out_t            guid_q[$];

	int unsigned cycles = 0;
	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned idents_sent = 0;
	int unsigned guids_checked = 0;
	int unsigned reg_writes = 0;
	bit          tx_idle_en = 1'b0;
	bit          rx_idle_en = 1'b0;
	int unsigned hold_req = 0;

	disk_guid_hash dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.guid_valid (guid_valid),
		.guid_stall (guid_stall),
		.guid       (guid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("%0t timeout, %0d guids still expected", $time, guid_q.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic void seed_lanes_m();
		fnv_acc = FNV_BASIS;
		sum_acc = FNV_PRIME;
	endfunction

	// fold one accepted transfer, queue a guid when it closes the identifier
	function automatic void predict_guid(dgh_in_t it);
		dgh_out_t g;
		if (!it.no_byte) begin
			fnv_acc = (fnv_acc ^ {56'd0, it.id_byte}) * FNV_PRIME;
			sum_acc = (sum_acc + {56'd0, it.id_byte}) * FNV_BASIS;
		end
		if (it.last) begin
			g.guid_low = fnv_acc ^ capacity_m;
			g.guid_high = sum_acc ^ {{(64 - SectorW){1'b0}}, sector_m};
			g.guid_low[55:52] = GUID_VERSION;
			g.guid_high[7:6] = GUID_VARIANT;
			guid_q.push_back(g);
			seed_lanes_m();
		end
	endfunction

	// receiver side: random stall bursts, or a long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				guid_stall <= 1'b1;
				repeat (hold_req) @(posedge clk);
				hold_req = 0;
				guid_stall <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				guid_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				guid_stall <= 1'b0;
			end else begin
				guid_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : guid_check
		dgh_out_t want;
		if (arst_n && guid_valid && !guid_stall) begin
			if (guid_q.size() == 0) begin
				$display("%0t unexpected guid: expected none actual %h", $time, guid);
				errors++;
			end else begin
				want = guid_q.pop_front();
				guids_checked++;
				if (guid.guid_low !== want.guid_low) begin
					$display("%0t guid_low mismatch: expected %h actual %h",
						$time, want.guid_low, guid.guid_low);
					errors++;
				end
				if (guid.guid_high !== want.guid_high) begin
					$display("%0t guid_high mismatch: expected %h actual %h",
						$time, want.guid_high, guid.guid_high);
					errors++;
				end
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input bit nb, input bit lst);
		dgh_in_t it;
		it.id_byte = b;
		it.no_byte = nb;
		it.last = lst;
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= it;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		predict_guid(it);
		items_sent++;
		if (lst) idents_sent++;
	endtask

	// let every guid drain and the byte datapath settle
	task automatic wait_idle();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (guid_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input dgh_cfg_idx_t idx, input logic [63:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		if (idx == CFG_CAPACITY) capacity_m = d;
		else sector_m = d[SectorW-1:0];
		reg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random identifier, with stray no-byte transfers and sometimes a no-byte close
	task automatic send_ident(input int unsigned len);
		bit split_close;
		split_close = ($urandom_range(0, 9) == 0);
		if (len == 0) begin
			send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		end else begin
			for (int unsigned i = 0; i < len; i++) begin
				if ($urandom_range(0, 15) == 0)
					send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
				send_item(8'($urandom_range(0, 255)), 1'b0, (i == len - 1) && !split_close);
			end
			if (split_close) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		end
	endtask

	task automatic random_config();
		logic [63:0] d;
		case ($urandom_range(0, 3))
			0: d = '0;
			1: d = '1;
			default: d = {$urandom, $urandom};
		endcase
		write_reg(CFG_CAPACITY, d);
		case ($urandom_range(0, 7))
			0: d = 64'd1;
			1: d = 64'd65536;
			2: d = 64'd0;
			3: d = 64'h1ffff;
			4: d = 64'd512;
			default: d = {$urandom, $urandom};
		endcase
		write_reg(CFG_SECTOR, d);
	endtask

	task automatic test_empty_identifier();
		send_item(8'ha5, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
	endtask

	task automatic test_byte_extremes();
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h01, 1'b0, 1'b0);
		send_item(8'h80, 1'b0, 1'b0);
		send_item(8'h7f, 1'b0, 1'b0);
		send_item(8'h55, 1'b0, 1'b0);
		send_item(8'haa, 1'b0, 1'b1);
		send_item(8'hff, 1'b0, 1'b1);
	endtask

	task automatic test_no_byte_items();
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h3c, 1'b0, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'hc3, 1'b0, 1'b1);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'hff, 1'b1, 1'b1);
	endtask

	task automatic test_register_extremes();
		wait_idle();
		write_reg(CFG_CAPACITY, '1);
		write_reg(CFG_SECTOR, 64'd0);
		send_item(8'h41, 1'b0, 1'b1);
		wait_idle();
		write_reg(CFG_CAPACITY, '0);
		write_reg(CFG_SECTOR, 64'd65536);
		send_item(8'h42, 1'b0, 1'b1);
		wait_idle();
		// upper write data bits beyond the sector field must be dropped
		write_reg(CFG_CAPACITY, {$urandom, $urandom});
		write_reg(CFG_SECTOR, '1);
		send_item(8'h43, 1'b0, 1'b1);
		wait_idle();
		write_reg(CFG_SECTOR, 64'd1);
		send_item(8'h44, 1'b1, 1'b1);
	endtask

	// registers only count at the closing transfer
	task automatic test_mid_identifier_config();
		send_item(8'h11, 1'b0, 1'b0);
		wait_idle();
		write_reg(CFG_CAPACITY, 64'h0123_4567_89ab_cdef);
		write_reg(CFG_SECTOR, 64'd4096);
		send_item(8'h22, 1'b0, 1'b1);
	endtask

	task automatic test_random_identifiers(input int unsigned n_items);
		int unsigned stop_at;
		int unsigned next_cfg;
		stop_at = items_sent + n_items;
		next_cfg = items_sent + $urandom_range(80, 200);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		while (items_sent < stop_at) begin
			if (items_sent >= next_cfg) begin
				wait_idle();
				random_config();
				next_cfg = items_sent + $urandom_range(80, 200);
			end
			if ($urandom_range(0, 19) == 0) send_ident(0);
			else if ($urandom_range(0, 9) == 0) send_ident($urandom_range(17, 40));
			else send_ident($urandom_range(1, 8));
		end
	endtask

	// receiver holds off while short identifiers keep arriving
	task automatic test_backpressure();
		wait_idle();
		tx_idle_en = 1'b0;
		hold_req = 300;
		for (int i = 0; i < 12; i++) send_ident($urandom_range(0, 3));
		wait_idle();
	endtask

	task automatic test_no_idling(input int unsigned n_items);
		int unsigned stop_at;
		stop_at = items_sent + n_items;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		wait_idle();
		random_config();
		while (items_sent < stop_at) send_ident($urandom_range(0, 6));
	endtask

	initial begin
		capacity_m = '0;
		sector_m = SECTOR_RESET;
		seed_lanes_m();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_identifier();
		test_byte_extremes();
		test_no_byte_items();
		test_register_extremes();
		test_mid_identifier_config();
		test_random_identifiers(1500);
		test_backpressure();
		test_no_idling(400);

		wait_idle();
		$display("covered %0d transfers in %0d identifiers over %0d register writes",
			items_sent, idents_sent, reg_writes);
		$display("%0d guids checked, %0d mismatches", guids_checked, errors);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
